// ===== hdl/bph_pkg.sv =====
// Shared types, constants and helpers of the binned pixel histogram.
package bph_pkg;

	localparam int MAX_BINS   = 256;
	localparam int COUNT_BITS = 24;

	localparam int SAMPLE_W    = 8;
	localparam int BIN_CNT_W   = 9;
	localparam int LEVEL_SHIFT = SAMPLE_W;
	localparam int TALLY_W     = 24;
	localparam int LANES       = 3;
	localparam int RES_W       = LANES * TALLY_W;
	localparam int ADDR_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int EXT_W       = (COUNT_BITS > TALLY_W) ? COUNT_BITS : TALLY_W;
	localparam int PROD_W      = SAMPLE_W + BIN_CNT_W;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic REG_BIN_COUNT   = 1'b0;
	localparam logic REG_COLOUR_MODE = 1'b1;

	localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RST = BIN_CNT_W'(256);
	localparam logic [BIN_CNT_W-1:0] BINS_LIMIT    = BIN_CNT_W'(MAX_BINS);
	localparam logic [ADDR_W-1:0]    LAST_ADDR     = ADDR_W'(MAX_BINS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

	typedef struct packed {
		logic count;
		logic read;
		logic clear;
	} lane_op_t;

	typedef struct packed {
		logic              busy;
		logic [ADDR_W-1:0] addr;
	} sweep_t;

	// Clamp the raw bin count register into 1..MAX_BINS.
	function automatic logic [BIN_CNT_W-1:0] clamp_bins(input logic [BIN_CNT_W-1:0] raw);
		logic [BIN_CNT_W-1:0] b;
		b = raw;
		if (raw == '0)
			b = BIN_CNT_W'(1);
		else if (raw > BINS_LIMIT)
			b = BINS_LIMIT;
		return b;
	endfunction

	// Low tally bits of a count, zero filled when the count is narrower.
	function automatic logic [TALLY_W-1:0] to_tally(input logic [COUNT_BITS-1:0] cnt);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(cnt);
		return ext[TALLY_W-1:0];
	endfunction

endpackage

// ===== hdl/bph_ram.sv =====
// Generic single write port RAM with one registered read port.
module bph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read-first: a same-edge write is not seen
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bph_lane.sv =====
// One histogram channel: bin mapping, count store and read-modify-write stage.
module bph_lane import bph_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_op_t             op,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [ADDR_W-1:0]    read_addr,
	input  logic [BIN_CNT_W-1:0] bins_used,
	input  sweep_t               sweep,
	output logic [TALLY_W-1:0]   tally
);

	logic [PROD_W-1:0]     prod;
	logic [ADDR_W-1:0]     bin_addr;
	logic [ADDR_W-1:0]     raddr;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] base;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;

	lane_op_t              op_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  fwd_vld_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	// bin = (sample * bins_used) >> 8, always below bins_used
	assign prod     = PROD_W'(sample) * PROD_W'(bins_used);
	assign bin_addr = ADDR_W'(prod >> LEVEL_SHIFT);
	assign raddr    = op.read ? read_addr : bin_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
	end

	// the previous write lands on the same edge as this read, so bypass it
	assign base = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		priority if (sweep.busy) begin
			we    = 1'b1;
			waddr = sweep.addr;
		end else if (op_s1.clear) begin
			we = 1'b1;
		end else if (op_s1.count) begin
			we    = 1'b1;
			wdata = (base == COUNT_MAX) ? base : base + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
	end

	assign tally = op_s1.read ? to_tally(base) : '0;

	bph_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

// ===== hdl/bph_outq.sv =====
// Two-entry result queue that decouples the count pipeline from the receiver.
module bph_outq import bph_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [RES_W-1:0] push_data,
	input  logic             pop_ready,
	output logic             pop_valid,
	output logic [RES_W-1:0] pop_data,
	output logic [1:0]       occ
);

	logic [RES_W-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;
	assign occ       = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/binned_pixel_histogram.sv =====
// Top level of the binned pixel histogram: config registers, lanes, result merge.
//
// Input stream (s_axis): one item per handshake. s_axis_tuser is the kind:
// 0 counts a pixel, 1 reads one bin. A pixel adds one to bin
// (value*bins)>>8 of channel 0, and of channels 1 and 2 in colour mode;
// it gives no result. A read returns the three counts of read_bin on
// m_axis and, with clear_after_read, zeroes that bin in all channels.
// Counts saturate at their maximum.
// Throughput: one item per cycle while s_axis_tready is high, pixels and
// reads mixed freely. Each channel lane reads its count RAM once per item
// and writes it on a count or clear; a one-deep write bypass covers
// back-to-back hits on the same bin. Read results pass the lane stage into
// a two-entry result queue that absorbs receiver stalls. Outside the reset
// sweep, s_axis_tready drops only when that queue and the pipeline stage
// hold two pending results and the receiver does not take one this cycle.
// Reset: bin_count returns to 256, colour_mode to grey, and the count RAMs
// are zeroed by a sweep over all MAX_BINS (256) entries during which
// s_axis_tready stays low; APB writes are taken throughout.
// APB: bin_count at 0x0, colour_mode at 0x4; pready is always high.
module binned_pixel_histogram import bph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] sample_c0, [15:8] sample_c1, [23:16] sample_c2,
	// [31:24] read_bin, [32] clear_after_read, [39:33] zero
	input  logic [39:0] s_axis_tdata,
	// [0] kind
	input  logic [0:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [23:0] tally_c0, [47:24] tally_c1, [71:48] tally_c2
	output logic [71:0] m_axis_tdata
);

	logic [BIN_CNT_W-1:0] bin_count_q;
	logic                 colour_mode_q;
	logic [BIN_CNT_W-1:0] bins_used;
	logic                 cfg_wr;
	logic                 reg_sel;

	logic                 sweep_busy_q;
	logic [ADDR_W-1:0]    sweep_addr_q;
	sweep_t               sweep;

	logic                 accept;
	logic                 kind;
	logic [SAMPLE_W-1:0]  samples [LANES];
	logic [SAMPLE_W-1:0]  read_bin;
	logic                 clear_after_read;
	logic                 in_range;
	logic [ADDR_W-1:0]    read_addr;
	lane_op_t             ops [LANES];
	logic [TALLY_W-1:0]   tallies [LANES];

	logic                 res_s1;
	logic [1:0]           occ;
	logic [2:0]           pending;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q   <= BIN_COUNT_RST;
			colour_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_BIN_COUNT:   bin_count_q   <= pwdata[BIN_CNT_W-1:0];
				REG_COLOUR_MODE: colour_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BIN_COUNT:   prdata = 32'(bin_count_q);
			REG_COLOUR_MODE: prdata = 32'(colour_mode_q);
			default:         prdata = '0;
		endcase
	end

	assign bins_used = clamp_bins(bin_count_q);

	// ---- clearing sweep after reset: one entry per cycle in every lane ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_busy_q <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_busy_q) begin
			if (sweep_addr_q == LAST_ADDR)
				sweep_busy_q <= 1'b0;
			else
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
		end
	end

	assign sweep.busy = sweep_busy_q;
	assign sweep.addr = sweep_addr_q;

	// ---- input unpack and per-lane commands ----
	assign kind             = s_axis_tuser[0];
	assign samples[0]       = s_axis_tdata[7:0];
	assign samples[1]       = s_axis_tdata[15:8];
	assign samples[2]       = s_axis_tdata[23:16];
	assign read_bin         = s_axis_tdata[31:24];
	assign clear_after_read = s_axis_tdata[32];

	// a read beyond the store returns zeros and clears nothing
	assign in_range  = (BIN_CNT_W'(read_bin) < BINS_LIMIT);
	assign read_addr = ADDR_W'(read_bin);

	// hold input while the pipeline and queue already own two results,
	// unless the receiver drains one this cycle
	assign pending       = 3'(occ) + 3'(res_s1);
	assign s_axis_tready = !sweep_busy_q
		&& (pending < 3'd2 || (occ != 2'd0 && m_axis_tready));
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ops[i].count = accept && kind == KIND_PIXEL && (i == 0 || colour_mode_q);
			ops[i].read  = accept && kind == KIND_READ && in_range;
			ops[i].clear = accept && kind == KIND_READ && in_range && clear_after_read;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bph_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (ops[g]),
			.sample   (samples[g]),
			.read_addr(read_addr),
			.bins_used(bins_used),
			.sweep    (sweep),
			.tally    (tallies[g])
		);
	end

	// ---- merge: every read item, in range or not, yields one result ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= 1'b0;
		end else begin
			res_s1 <= accept && kind == KIND_READ;
		end
	end

	bph_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_s1),
		.push_data({tallies[2], tallies[1], tallies[0]}),
		.pop_ready(m_axis_tready),
		.pop_valid(m_axis_tvalid),
		.pop_data (m_axis_tdata),
		.occ      (occ)
	);

endmodule
